// ----- rtl/core/apbo_pkg.sv -----
package apbo_pkg;

    // Default capacity of the box store for one frame.
    localparam int MAX_BOXES_DEF = 32;

    // Edge values are 18-bit two's complement, wide enough for every box.
    localparam int EDGE_W = 18;

    // Result indices are 5-bit fields.
    localparam int INDEX_W = 5;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EDGE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_CLOSE = 4'b1000
    } t_state;

    // One stored box: its left, right, top and bottom edges side by side.
    typedef struct packed {
        logic signed [EDGE_W-1:0] left;
        logic signed [EDGE_W-1:0] right;
        logic signed [EDGE_W-1:0] top;
        logic signed [EDGE_W-1:0] bottom;
    } t_box;

endpackage

// ----- rtl/core/all_pairs_box_overlap.sv -----
// A box is taken when start is high and busy is low; busy then stays high through the edge,
// scan and close states, the scan being skipped when the store is full.
// The stored boxes are read back from one memory port, one box per cycle.
// Hit beats follow one per overlapping box; the closing beat shows in the first idle cycle.
// Each result beat is shown for one cycle only; the receiver cannot stall the block.
// Synchronous active-low reset empties the store and clears the overflow flag at once.
module all_pairs_box_overlap
    import apbo_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [15:0]        i_pos_x,
    input  logic signed [15:0]        i_pos_y,
    input  logic signed [15:0]        i_off_x,
    input  logic signed [15:0]        i_off_y,
    input  logic        [11:0]        i_dim_x,
    input  logic        [11:0]        i_dim_y,
    input  logic        [3:0]         i_scale_x,
    input  logic        [3:0]         i_scale_y,
    input  logic                      i_frame_end,
    output logic                      o_strobe,
    output logic        [INDEX_W-1:0] o_first_index,
    output logic        [INDEX_W-1:0] o_second_index,
    output logic                      o_hit,
    output logic                      o_overflow,
    output logic                      o_last
);

    localparam int IW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_BOXES);

    t_state r_state;
    t_state n_state;

    // Captured input beat.
    logic signed [15:0] r_pos_x;
    logic signed [15:0] r_pos_y;
    logic signed [15:0] r_off_x;
    logic signed [15:0] r_off_y;
    logic        [11:0] r_dim_x;
    logic        [11:0] r_dim_y;
    logic        [3:0]  r_scale_x;
    logic        [3:0]  r_scale_y;
    logic               r_frame_end;

    // Edges of the current box.
    t_box r_cur;

    // Frame bookkeeping.
    logic [CW-1:0] r_count;
    logic          r_ovf;

    // Scan pipeline: read issue index, then compare stage.
    logic [CW-1:0] r_rd_idx;
    logic          r_cmp_vld;
    logic [IW-1:0] r_cmp_idx;
    t_box          r_rd_data;

    // Store of earlier boxes.
    t_box r_mem [MAX_BOXES];

    // Result register.
    logic               r_strobe;
    logic [INDEX_W-1:0] r_first;
    logic [INDEX_W-1:0] r_second;
    logic               r_hit;
    logic               r_ovf_out;
    logic               r_last;

    logic accept;
    logic full;
    logic rd_en;
    logic wr_en;
    logic overlap;
    logic signed [EDGE_W-1:0] n_left;
    logic signed [EDGE_W-1:0] n_top;
    logic        [15:0]       prod_x;
    logic        [15:0]       prod_y;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign full   = (r_count == FULL_COUNT);
    assign rd_en  = (r_state == S_SCAN) && (r_rd_idx != r_count);
    assign wr_en  = (r_state == S_CLOSE) && !full;

    // Edge arithmetic: one add for the near edge, a small product for the extent.
    assign n_left = EDGE_W'(r_pos_x) + EDGE_W'(r_off_x);
    assign n_top  = EDGE_W'(r_pos_y) + EDGE_W'(r_off_y);
    assign prod_x = 16'(r_dim_x) * 16'(r_scale_x);
    assign prod_y = 16'(r_dim_y) * 16'(r_scale_y);

    // Inclusive overlap test against the stored box just read.
    assign overlap = (r_cur.right >= r_rd_data.left) && (r_cur.left <= r_rd_data.right) &&
                     (r_cur.bottom >= r_rd_data.top) && (r_cur.top <= r_rd_data.bottom);

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_EDGE;
            end
            S_EDGE: begin
                n_state = full ? S_CLOSE : S_SCAN;
            end
            S_SCAN: begin
                if (r_rd_idx == r_count) n_state = S_CLOSE;
            end
            S_CLOSE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= rd_en;
            r_strobe  <= (r_cmp_vld && overlap) || (r_state == S_CLOSE);
            if (r_state == S_EDGE) begin
                r_rd_idx <= '0;
            end else if (rd_en) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (r_state == S_CLOSE) begin
                if (r_frame_end) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end else if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // Input capture and edge registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos_x     <= i_pos_x;
            r_pos_y     <= i_pos_y;
            r_off_x     <= i_off_x;
            r_off_y     <= i_off_y;
            r_dim_x     <= i_dim_x;
            r_dim_y     <= i_dim_y;
            r_scale_x   <= i_scale_x;
            r_scale_y   <= i_scale_y;
            r_frame_end <= i_frame_end;
        end
        if (r_state == S_EDGE) begin
            r_cur.left   <= n_left;
            r_cur.top    <= n_top;
            r_cur.right  <= n_left + $signed({2'b00, prod_x});
            r_cur.bottom <= n_top + $signed({2'b00, prod_y});
        end
    end

    // Box store: one read port for the scan, one write at the close.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_idx[IW-1:0]];
            r_cmp_idx <= r_rd_idx[IW-1:0];
        end
        if (wr_en) begin
            r_mem[r_count[IW-1:0]] <= r_cur;
        end
    end

    // Result register: hit beats from the compare stage, closing beat at the close.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLOSE) begin
            r_first   <= '0;
            r_second  <= full ? '0 : INDEX_W'(r_count);
            r_hit     <= 1'b0;
            r_ovf_out <= full ? 1'b1 : r_ovf;
            r_last    <= 1'b1;
        end else begin
            r_first   <= INDEX_W'(r_cmp_idx);
            r_second  <= INDEX_W'(r_count);
            r_hit     <= 1'b1;
            r_ovf_out <= r_ovf;
            r_last    <= 1'b0;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_first_index  = r_first;
    assign o_second_index = r_second;
    assign o_hit          = r_hit;
    assign o_overflow     = r_ovf_out;
    assign o_last         = r_last;

    // An accepted box always makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted box did not raise busy");

    // Every beat is either a hit or the closing beat, never both.
    a_hit_xor_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_hit != o_last))
        else $error("result beat is both or neither hit and closing");

    // The closing beat is followed by a quiet cycle.
    a_close_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("result beat right after a closing beat");

    // The store never holds more boxes than its capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("box count beyond capacity");

    // No read is issued outside the scan.
    a_read_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> $past(r_state == S_SCAN))
        else $error("compare stage fed outside the scan");

endmodule

// ----- dv/box_pair_checker.sv -----
// Watches the box and result channels of the all-pairs overlap block.
// It keeps its own copy of the frame's box store, works out the beats that each
// accepted box must cause, and compares every result beat with the oldest one.
module box_pair_checker
    import apbo_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic signed [15:0]        i_pos_x,
    input  logic signed [15:0]        i_pos_y,
    input  logic signed [15:0]        i_off_x,
    input  logic signed [15:0]        i_off_y,
    input  logic        [11:0]        i_dim_x,
    input  logic        [11:0]        i_dim_y,
    input  logic        [3:0]         i_scale_x,
    input  logic        [3:0]         i_scale_y,
    input  logic                      i_frame_end,
    input  logic                      i_strobe,
    input  logic        [INDEX_W-1:0] i_first_index,
    input  logic        [INDEX_W-1:0] i_second_index,
    input  logic                      i_hit,
    input  logic                      i_overflow,
    input  logic                      i_last,
    output int                        o_fail_count,
    output int                        o_pending
);

    // One result beat as the block should present it.
    typedef struct {
        logic [INDEX_W-1:0] first_index;
        logic [INDEX_W-1:0] second_index;
        logic               hit;
        logic               overflow;
        logic               last;
    } t_pair_beat;

    t_pair_beat               pending_pairs[$];
    logic signed [EDGE_W-1:0] box_left[MAX_BOXES_DEF];
    logic signed [EDGE_W-1:0] box_right[MAX_BOXES_DEF];
    logic signed [EDGE_W-1:0] box_top[MAX_BOXES_DEF];
    logic signed [EDGE_W-1:0] box_bottom[MAX_BOXES_DEF];
    int                       stored_count = 0;
    logic                     frame_overflow = 1'b0;
    int                       fail_count = 0;

    // Reports a field that differs from its expected value, X and Z included.
    function automatic bit field_ok(input string name, input logic [INDEX_W-1:0] want,
                                    input logic [INDEX_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Forms the edges of a new box; unless the store is full, queues a hit beat for every
    // stored box that it touches and stores it; then queues the closing beat.
    function automatic void predict_pairs(
        input logic signed [15:0] pos_x,
        input logic signed [15:0] pos_y,
        input logic signed [15:0] off_x,
        input logic signed [15:0] off_y,
        input logic        [11:0] dim_x,
        input logic        [11:0] dim_y,
        input logic        [3:0]  scale_x,
        input logic        [3:0]  scale_y,
        input logic               frame_end
    );
        logic signed [EDGE_W-1:0] left;
        logic signed [EDGE_W-1:0] right;
        logic signed [EDGE_W-1:0] top;
        logic signed [EDGE_W-1:0] bottom;
        logic        [15:0]       span_x;
        logic        [15:0]       span_y;
        t_pair_beat               beat;
        int                       k;

        left   = EDGE_W'(pos_x) + EDGE_W'(off_x);
        top    = EDGE_W'(pos_y) + EDGE_W'(off_y);
        span_x = 16'(dim_x) * 16'(scale_x);
        span_y = 16'(dim_y) * 16'(scale_y);
        right  = left + $signed({2'b00, span_x});
        bottom = top + $signed({2'b00, span_y});

        if (stored_count >= MAX_BOXES_DEF) begin
            // A full store drops the box and only reports the overflow.
            frame_overflow = 1'b1;
            beat = '{first_index: '0, second_index: '0, hit: 1'b0, overflow: 1'b1,
                     last: 1'b1};
            pending_pairs.push_back(beat);
        end else begin
            for (k = 0; k < stored_count; k++) begin
                if (right >= box_left[k] && left <= box_right[k] &&
                    bottom >= box_top[k] && top <= box_bottom[k]) begin
                    beat.first_index  = k[INDEX_W-1:0];
                    beat.second_index = stored_count[INDEX_W-1:0];
                    beat.hit          = 1'b1;
                    beat.overflow     = frame_overflow;
                    beat.last         = 1'b0;
                    pending_pairs.push_back(beat);
                end
            end
            box_left[stored_count]   = left;
            box_right[stored_count]  = right;
            box_top[stored_count]    = top;
            box_bottom[stored_count] = bottom;
            beat = '{first_index: '0, second_index: stored_count[INDEX_W-1:0], hit: 1'b0,
                     overflow: frame_overflow, last: 1'b1};
            pending_pairs.push_back(beat);
            stored_count++;
        end

        // The last box of a frame empties the store for the next one.
        if (frame_end) begin
            stored_count   = 0;
            frame_overflow = 1'b0;
        end
    endfunction

    // Result beats are checked before the box taken at the same edge is predicted,
    // since any beat seen there belongs to an earlier box.
    always @(posedge i_clk) begin
        t_pair_beat want;
        if (!i_rst_n) begin
            pending_pairs.delete();
            stored_count   = 0;
            frame_overflow = 1'b0;
        end else begin
            if (i_strobe) begin
                if (pending_pairs.size() == 0) begin
                    $error("result beat with nothing expected: first %0d second %0d hit %0b",
                           i_first_index, i_second_index, i_hit);
                    fail_count++;
                end else begin
                    want = pending_pairs.pop_front();
                    if (!field_ok("first_index", want.first_index, i_first_index))
                        fail_count++;
                    if (!field_ok("second_index", want.second_index, i_second_index))
                        fail_count++;
                    if (!field_ok("hit", INDEX_W'(want.hit), INDEX_W'(i_hit)))
                        fail_count++;
                    if (!field_ok("overflow", INDEX_W'(want.overflow), INDEX_W'(i_overflow)))
                        fail_count++;
                    if (!field_ok("last", INDEX_W'(want.last), INDEX_W'(i_last)))
                        fail_count++;
                end
            end
            if (start && !busy) begin
                predict_pairs(i_pos_x, i_pos_y, i_off_x, i_off_y, i_dim_x, i_dim_y,
                              i_scale_x, i_scale_y, i_frame_end);
            end
        end
        o_pending    <= pending_pairs.size();
        o_fail_count <= fail_count;
    end

endmodule

// ----- dv/all_pairs_box_overlap_test.sv -----
// Drives frames of boxes into the all-pairs overlap block and gives the verdict.
// A directed set of edge cases comes first, then random frames: mostly clustered
// boxes that collide often, some boxes spread over the full field ranges, and a few
// frames longer than the store so that the overflow path is taken.
module all_pairs_box_overlap_test;
    import apbo_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = MAX_BOXES_DEF + 8;
    localparam int RANDOM_BOXES = 310;
    localparam int PHASE_BOXES  = RANDOM_BOXES / 3;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic signed [15:0]        pos_x;
    logic signed [15:0]        pos_y;
    logic signed [15:0]        off_x;
    logic signed [15:0]        off_y;
    logic        [11:0]        dim_x;
    logic        [11:0]        dim_y;
    logic        [3:0]         scale_x;
    logic        [3:0]         scale_y;
    logic                      frame_end;
    logic                      strobe;
    logic        [INDEX_W-1:0] first_index;
    logic        [INDEX_W-1:0] second_index;
    logic                      hit;
    logic                      overflow;
    logic                      last;
    int                        fail_count;
    int                        pending;
    int                        idle_pct = 0;
    int                        cycle_count = 0;

    always #1 i_clk = ~i_clk;

    all_pairs_box_overlap dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_pos_x        (pos_x),
        .i_pos_y        (pos_y),
        .i_off_x        (off_x),
        .i_off_y        (off_y),
        .i_dim_x        (dim_x),
        .i_dim_y        (dim_y),
        .i_scale_x      (scale_x),
        .i_scale_y      (scale_y),
        .i_frame_end    (frame_end),
        .o_strobe       (strobe),
        .o_first_index  (first_index),
        .o_second_index (second_index),
        .o_hit          (hit),
        .o_overflow     (overflow),
        .o_last         (last)
    );

    box_pair_checker pair_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_pos_x        (pos_x),
        .i_pos_y        (pos_y),
        .i_off_x        (off_x),
        .i_off_y        (off_y),
        .i_dim_x        (dim_x),
        .i_dim_y        (dim_y),
        .i_scale_x      (scale_x),
        .i_scale_y      (scale_y),
        .i_frame_end    (frame_end),
        .i_strobe       (strobe),
        .i_first_index  (first_index),
        .i_second_index (second_index),
        .i_hit          (hit),
        .i_overflow     (overflow),
        .i_last         (last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Watchdog against a hung handshake or results that never come.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offers one box after a random gap and returns at the edge that takes it.
    // Start stays high afterwards so that back-to-back boxes need no extra step.
    task automatic send_box(input logic signed [15:0] px, input logic signed [15:0] py,
                            input logic signed [15:0] ox, input logic signed [15:0] oy,
                            input logic [11:0] dx, input logic [11:0] dy,
                            input logic [3:0] sx, input logic [3:0] sy,
                            input logic end_of_frame);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        pos_x     <= px;
        pos_y     <= py;
        off_x     <= ox;
        off_y     <= oy;
        dim_x     <= dx;
        dim_y     <= dy;
        scale_x   <= sx;
        scale_y   <= sy;
        frame_end <= end_of_frame;
        do @(posedge i_clk); while (busy);
    endtask

    // Holds off new boxes until every expected beat has been seen.
    task automatic wait_for_results;
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] ox;
        logic signed [15:0] oy;
        logic        [11:0] dx;
        logic        [11:0] dy;
        logic        [3:0]  sx;
        logic        [3:0]  sy;
        int                 sent;
        int                 frame_len;
        int                 k;

        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        pos_x     <= '0;
        pos_y     <= '0;
        off_x     <= '0;
        off_y     <= '0;
        dim_x     <= '0;
        dim_y     <= '0;
        scale_x   <= '0;
        scale_y   <= '0;
        frame_end <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frame: identical boxes, edges that touch, boxes one pixel apart,
        // both corners of the edge range, a box covering the rest, and boxes
        // reduced to a point by a zero scale or a zero size.
        idle_pct = 35;
        send_box(0, 0, 0, 0, 10, 10, 1, 1, 1'b0);
        send_box(0, 0, 0, 0, 10, 10, 1, 1, 1'b0);
        send_box(10, 0, 0, 0, 5, 5, 2, 2, 1'b0);
        send_box(21, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        send_box(-32768, -32768, -32768, -32768, 4095, 4095, 15, 15, 1'b0);
        send_box(32767, 32767, 32767, 32767, 4095, 4095, 15, 15, 1'b0);
        send_box(0, 0, -30000, -30000, 4095, 4095, 15, 15, 1'b0);
        send_box(5, 5, 0, 0, 4095, 4095, 0, 0, 1'b0);
        send_box(3, 3, 0, 0, 0, 0, 15, 15, 1'b1);

        // A frame of a single box.
        send_box(100, -100, -50, 50, 7, 9, 3, 2, 1'b1);

        // Separation and contact along y, then a miss by one pixel along x.
        send_box(0, 0, 0, 0, 10, 10, 1, 1, 1'b0);
        send_box(5, 11, 0, 0, 3, 3, 1, 1, 1'b0);
        send_box(5, 5, 0, 5, 3, 3, 1, 1, 1'b0);
        send_box(-20, 0, 9, 0, 10, 10, 1, 1, 1'b1);
        wait_for_results();

        // Random frames. The first one overruns the store on purpose.
        sent      = 0;
        frame_len = MAX_BOXES_DEF + 2;
        while (sent < RANDOM_BOXES) begin
            for (k = 0; k < frame_len; k++) begin
                if ($urandom_range(99) < 75) begin
                    // Clustered boxes near the origin, so pairs are common.
                    px = 16'($urandom_range(200) - 100);
                    py = 16'($urandom_range(200) - 100);
                    ox = 16'($urandom_range(40) - 20);
                    oy = 16'($urandom_range(40) - 20);
                    dx = 12'($urandom_range(30));
                    dy = 12'($urandom_range(30));
                    sx = 4'($urandom_range(4));
                    sy = 4'($urandom_range(4));
                end else begin
                    px = 16'($urandom);
                    py = 16'($urandom);
                    ox = 16'($urandom);
                    oy = 16'($urandom);
                    dx = 12'($urandom);
                    dy = 12'($urandom);
                    sx = 4'($urandom);
                    sy = 4'($urandom);
                end
                send_box(px, py, ox, oy, dx, dy, sx, sy, k == frame_len - 1);
                sent++;

                // Idle pattern changes between phases, each after a full drain.
                if (sent == PHASE_BOXES) begin
                    wait_for_results();
                    idle_pct = 83;
                end else if (sent == 2 * PHASE_BOXES) begin
                    wait_for_results();
                    idle_pct = 0;
                end
            end

            case ($urandom_range(9))
                0:       frame_len = $urandom_range(MAX_BOXES_DEF + 5, MAX_BOXES_DEF + 1);
                1, 2:    frame_len = $urandom_range(MAX_BOXES_DEF, 13);
                default: frame_len = $urandom_range(12, 1);
            endcase
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/apbo_pkg.sv
rtl/core/all_pairs_box_overlap.sv
dv/box_pair_checker.sv
dv/all_pairs_box_overlap_test.sv
